// ----- rtl/modified_utf8_to_quoted_literal_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the quoted literal converter
// Shared clocking and reset handling for the concurrent checks.
// ---------------------------------------------------------------------------
`ifndef MODIFIED_UTF8_TO_QUOTED_LITERAL_TOP_ASSERT_SVH
`define MODIFIED_UTF8_TO_QUOTED_LITERAL_TOP_ASSERT_SVH

// condition holds at every edge outside reset
`define MU8QL_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// same-cycle implication
`define MU8QL_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define MU8QL_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/mu8ql_pkg.sv -----
// ---------------------------------------------------------------------------
// mu8ql_pkg
// Types, constants and text encoding helpers of the quoted literal converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mu8ql_pkg;

   // input opcodes
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // error codes on the result channel
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_INVALID = 2'd1;
   localparam logic [1:0] ERR_TRUNC   = 2'd2;

   localparam int CP_W       = 21;
   localparam int PEND_DEPTH = 5;
   localparam int POS_W      = 3;

   // byte and code point constants
   localparam logic [7:0] BYTE_SURR_LEAD = 8'hED;
   localparam logic [3:0] NIB_SURR_HI    = 4'hA;
   localparam logic [3:0] NIB_SURR_LO    = 4'hB;
   localparam logic [CP_W-1:0] PAIR_BASE = 21'h10000;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;

   typedef enum logic [2:0] {
      SEG_NONE,
      SEG_QUOTE,
      SEG_CHAR,
      SEG_PAIR,
      SEG_ERR
   } seg_kind_type;

   // one piece of output text: a quote, a code point, a pair or an error
   typedef struct packed {
      seg_kind_type    kind;
      logic [CP_W-1:0] cp;
      logic [1:0]      err;
   } seg_type;

   // everything one input item produces, in output order
   typedef struct packed {
      seg_type s0;
      seg_type s1;
      seg_type s2;
   } rec_type;

   function automatic seg_type mk_seg(seg_kind_type kind, logic [CP_W-1:0] cp,
                                      logic [1:0] err);
      seg_type s;
      s.kind = kind;
      s.cp   = cp;
      s.err  = err;
      return s;
   endfunction

   function automatic logic is_cont(logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   function automatic logic is_lead2(logic [7:0] b);
      return b[7:5] == 3'b110;
   endfunction

   function automatic logic is_lead3(logic [7:0] b);
      return b[7:4] == 4'b1110;
   endfunction

   // second byte of a two-character escape, zero when none applies
   function automatic logic [7:0] esc_char(logic [15:0] c);
      logic [7:0] e;
      case (c)
         16'h0008: e = 8'h62;
         16'h0009: e = 8'h74;
         16'h000A: e = 8'h6E;
         16'h000C: e = 8'h66;
         16'h000D: e = 8'h72;
         16'h005C: e = CH_BSLASH;
         16'h0022: e = CH_QUOTE;
         default:  e = 8'h00;
      endcase
      return e;
   endfunction

   // code points written as a u escape when esc_char gives no two-character escape
   function automatic logic is_hidden(logic [15:0] c);
      return c inside {[16'h0000:16'h001F], [16'h007F:16'h009F],
                       [16'hD800:16'hDFFF], [16'hFFEF:16'hFFFF]};
   endfunction

   function automatic logic [7:0] hex_digit(logic [3:0] v, logic upper);
      logic [7:0] d;
      if (v < 4'd10) begin
         d = CH_ZERO + {4'd0, v};
      end else begin
         d = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, v} - 8'd10;
      end
      return d;
   endfunction

   // number of output bytes of one segment
   function automatic logic [POS_W-1:0] seg_len(seg_type s);
      logic [POS_W-1:0] n;
      logic [15:0]      c;
      c = s.cp[15:0];
      case (s.kind)
         SEG_QUOTE: n = 3'd1;
         SEG_ERR:   n = 3'd1;
         SEG_PAIR:  n = 3'd4;
         SEG_CHAR: begin
            if (esc_char(c) != 8'h00) n = 3'd2;
            else if (is_hidden(c))    n = 3'd6;
            else if (c < 16'h0080)    n = 3'd1;
            else if (c < 16'h0800)    n = 3'd2;
            else                      n = 3'd3;
         end
         default:   n = 3'd0;
      endcase
      return n;
   endfunction

   // byte at a position within one segment
   function automatic logic [7:0] seg_byte(seg_type s, logic [POS_W-1:0] pos,
                                           logic upper);
      logic [7:0]  b;
      logic [15:0] c;
      logic [7:0]  e;
      c = s.cp[15:0];
      e = esc_char(c);
      b = 8'h00;
      case (s.kind)
         SEG_QUOTE: b = CH_QUOTE;
         SEG_PAIR: begin
            case (pos)
               3'd0:    b = {5'b11110, s.cp[20:18]};
               3'd1:    b = {2'b10, s.cp[17:12]};
               3'd2:    b = {2'b10, s.cp[11:6]};
               default: b = {2'b10, s.cp[5:0]};
            endcase
         end
         SEG_CHAR: begin
            if (e != 8'h00) begin
               b = (pos == 3'd0) ? CH_BSLASH : e;
            end else if (is_hidden(c)) begin
               case (pos)
                  3'd0:    b = CH_BSLASH;
                  3'd1:    b = CH_U;
                  3'd2:    b = hex_digit(c[15:12], upper);
                  3'd3:    b = hex_digit(c[11:8], upper);
                  3'd4:    b = hex_digit(c[7:4], upper);
                  default: b = hex_digit(c[3:0], upper);
               endcase
            end else if (c < 16'h0080) begin
               b = c[7:0];
            end else if (c < 16'h0800) begin
               b = (pos == 3'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
            end else begin
               case (pos)
                  3'd0:    b = {4'b1110, c[15:12]};
                  3'd1:    b = {2'b10, c[11:6]};
                  default: b = {2'b10, c[5:0]};
               endcase
            end
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/mu8ql_dec.sv -----
// ---------------------------------------------------------------------------
// mu8ql_dec
// Input stage: pending byte buffer, sequence decoding and the record register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modified_utf8_to_quoted_literal_top_assert.svh"

module mu8ql_dec (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // in_byte
   input  logic               req_tuser,   // opcode
   output logic               rec_valid,
   output mu8ql_pkg::rec_type rec_data,
   input  logic               rec_take
);
   import mu8ql_pkg::*;

   logic [7:0]      pend_ff [PEND_DEPTH];
   logic [7:0]      pend_in [PEND_DEPTH];
   logic [2:0]      cnt_ff, cnt_in;
   logic            started_ff, started_in;
   logic            failed_ff, failed_in;
   logic            a_valid_ff, a_valid_in;
   rec_type         a_rec_ff, a_rec_in;
   logic            accept;
   logic            rec_empty;
   logic [7:0]      b;
   logic [CP_W-1:0] lone_cp;
   logic [CP_W-1:0] pair_cp;

   assign b          = req_tdata;
   assign req_tready = !a_valid_ff || rec_take;
   assign accept     = req_tvalid && req_tready;
   assign rec_valid  = a_valid_ff;
   assign rec_data   = a_rec_ff;

   // code point of a high surrogate waiting in the buffer, and of a full pair
   assign lone_cp = {5'd0, pend_ff[0][3:0], pend_ff[1][5:0], pend_ff[2][5:0]};
   assign pair_cp = PAIR_BASE +
                    {1'b0, pend_ff[1][3:0], pend_ff[2][5:0], pend_ff[4][3:0], b[5:0]};

   // decode the accepted item against the pending bytes
   always_comb begin
      a_rec_in   = '0;
      pend_in    = pend_ff;
      cnt_in     = cnt_ff;
      started_in = started_ff;
      failed_in  = failed_ff;
      if (accept) begin
         if (req_tuser == OP_END) begin
            if (!failed_ff) begin
               if (!started_ff) a_rec_in.s0 = mk_seg(SEG_QUOTE, '0, ERR_NONE);
               case (cnt_ff)
                  3'd0: a_rec_in.s2 = mk_seg(SEG_QUOTE, '0, ERR_NONE);
                  3'd1, 3'd2: a_rec_in.s2 = mk_seg(SEG_ERR, '0, ERR_TRUNC);
                  3'd3: begin
                     a_rec_in.s1 = mk_seg(SEG_CHAR, lone_cp, ERR_NONE);
                     a_rec_in.s2 = mk_seg(SEG_QUOTE, '0, ERR_NONE);
                  end
                  default: begin
                     a_rec_in.s1 = mk_seg(SEG_CHAR, lone_cp, ERR_NONE);
                     a_rec_in.s2 = mk_seg(SEG_ERR, '0, ERR_TRUNC);
                  end
               endcase
            end
            cnt_in     = 3'd0;
            started_in = 1'b0;
            failed_in  = 1'b0;
         end else if (!failed_ff) begin
            if (!started_ff) a_rec_in.s0 = mk_seg(SEG_QUOTE, '0, ERR_NONE);
            started_in = 1'b1;
            cnt_in     = 3'd0;
            case (cnt_ff)
               3'd0: begin
                  if (is_lead2(b) || is_lead3(b)) begin
                     pend_in[0] = b;
                     cnt_in     = 3'd1;
                  end else begin
                     a_rec_in.s1 = mk_seg(SEG_CHAR, {13'd0, b}, ERR_NONE);
                  end
               end
               3'd1: begin
                  if (is_lead3(pend_ff[0])) begin
                     pend_in[1] = b;
                     cnt_in     = 3'd2;
                  end else if (is_cont(b)) begin
                     a_rec_in.s1 = mk_seg(SEG_CHAR, {10'd0, pend_ff[0][4:0], b[5:0]},
                                          ERR_NONE);
                  end else begin
                     a_rec_in.s2 = mk_seg(SEG_ERR, '0, ERR_INVALID);
                     failed_in   = 1'b1;
                  end
               end
               3'd2: begin
                  if (!is_cont(pend_ff[1]) || !is_cont(b)) begin
                     a_rec_in.s2 = mk_seg(SEG_ERR, '0, ERR_INVALID);
                     failed_in   = 1'b1;
                  end else if (pend_ff[0] == BYTE_SURR_LEAD &&
                               pend_ff[1][7:4] == NIB_SURR_HI) begin
                     pend_in[2] = b;
                     cnt_in     = 3'd3;
                  end else begin
                     a_rec_in.s1 = mk_seg(SEG_CHAR,
                                          {5'd0, pend_ff[0][3:0], pend_ff[1][5:0], b[5:0]},
                                          ERR_NONE);
                  end
               end
               3'd3: begin
                  if (b == BYTE_SURR_LEAD) begin
                     pend_in[3] = b;
                     cnt_in     = 3'd4;
                  end else begin
                     a_rec_in.s1 = mk_seg(SEG_CHAR, lone_cp, ERR_NONE);
                     if (is_lead2(b) || is_lead3(b)) begin
                        pend_in[0] = b;
                        cnt_in     = 3'd1;
                     end else begin
                        a_rec_in.s2 = mk_seg(SEG_CHAR, {13'd0, b}, ERR_NONE);
                     end
                  end
               end
               3'd4: begin
                  if (b[7:4] == NIB_SURR_LO) begin
                     pend_in[4] = b;
                     cnt_in     = 3'd5;
                  end else begin
                     // lone high half out, the second lead byte waits again
                     a_rec_in.s1 = mk_seg(SEG_CHAR, lone_cp, ERR_NONE);
                     pend_in[0]  = pend_ff[3];
                     pend_in[1]  = b;
                     cnt_in      = 3'd2;
                  end
               end
               3'd5: begin
                  if (is_cont(b)) begin
                     a_rec_in.s1 = mk_seg(SEG_PAIR, pair_cp, ERR_NONE);
                  end else begin
                     a_rec_in.s1 = mk_seg(SEG_CHAR, lone_cp, ERR_NONE);
                     a_rec_in.s2 = mk_seg(SEG_ERR, '0, ERR_INVALID);
                     failed_in   = 1'b1;
                  end
               end
               default: cnt_in = 3'd0;
            endcase
         end
      end
   end

   // items that produce no text never enter the record register
   assign rec_empty = a_rec_in.s0.kind == SEG_NONE && a_rec_in.s1.kind == SEG_NONE &&
                      a_rec_in.s2.kind == SEG_NONE;
   assign a_valid_in = (accept && !rec_empty) || (a_valid_ff && !rec_take);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= 3'd0;
         started_ff <= 1'b0;
         failed_ff  <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         started_ff <= started_in;
         failed_ff  <= failed_in;
         a_valid_ff <= a_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (accept && !rec_empty) a_rec_ff <= a_rec_in;
   end

   `MU8QL_ASSERT_IMPLIES(a_failed_empty, failed_ff, cnt_ff == 3'd0, "failed string holds bytes")
   `MU8QL_ASSERT_IMPLIES(a_pend_started, cnt_ff != 3'd0, started_ff, "bytes pending before quote")
   `MU8QL_ASSERT_NEXT(a_rec_hold, a_valid_ff && !rec_take, a_valid_ff && $stable(a_rec_ff), "record lost while waiting")

endmodule

// ----- rtl/mu8ql_ser.sv -----
// ---------------------------------------------------------------------------
// mu8ql_ser
// Output stage: walks one record's segments, one byte a cycle while rsp_tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modified_utf8_to_quoted_literal_top_assert.svh"

module mu8ql_ser (
   input  logic               clock,
   input  logic               reset,
   input  logic               hex_upper,
   input  logic               rec_valid,
   input  mu8ql_pkg::rec_type rec_data,
   output logic               rec_take,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // out_byte
   output logic [1:0]         rsp_tuser,   // error_code
   output logic               rsp_tlast    // last_of_run
);
   import mu8ql_pkg::*;

   logic             b_valid_ff, b_valid_in;
   rec_type          rec_ff, rec_in;
   logic [1:0]       seg_ff, seg_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   seg_type          cur;
   logic [POS_W-1:0] cur_len;
   logic             at_end;
   logic             more_after;
   logic [1:0]       next_idx;
   logic             is_last;
   logic             xfer;
   logic             load;

   // current segment and what follows it
   always_comb begin
      case (seg_ff)
         2'd0: begin
            cur        = rec_ff.s0;
            more_after = rec_ff.s1.kind != SEG_NONE || rec_ff.s2.kind != SEG_NONE;
            next_idx   = (rec_ff.s1.kind != SEG_NONE) ? 2'd1 : 2'd2;
         end
         2'd1: begin
            cur        = rec_ff.s1;
            more_after = rec_ff.s2.kind != SEG_NONE;
            next_idx   = 2'd2;
         end
         default: begin
            cur        = rec_ff.s2;
            more_after = 1'b0;
            next_idx   = 2'd2;
         end
      endcase
   end

   assign cur_len = seg_len(cur);
   assign at_end  = pos_ff == cur_len - 3'd1;
   assign is_last = at_end && !more_after;

   // result channel
   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = seg_byte(cur, pos_ff, hex_upper);
   assign rsp_tuser  = (cur.kind == SEG_ERR) ? cur.err : ERR_NONE;
   assign rsp_tlast  = is_last;

   assign xfer     = rsp_tvalid && rsp_tready;
   assign rec_take = !b_valid_ff || (xfer && is_last);
   assign load     = rec_valid && rec_take;

   // position update
   always_comb begin
      b_valid_in = b_valid_ff;
      rec_in     = rec_ff;
      seg_in     = seg_ff;
      pos_in     = pos_ff;
      if (load) begin
         b_valid_in = 1'b1;
         rec_in     = rec_data;
         pos_in     = '0;
         if (rec_data.s0.kind != SEG_NONE)      seg_in = 2'd0;
         else if (rec_data.s1.kind != SEG_NONE) seg_in = 2'd1;
         else                                   seg_in = 2'd2;
      end else if (xfer) begin
         if (is_last) begin
            b_valid_in = 1'b0;
         end else if (at_end) begin
            seg_in = next_idx;
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      seg_ff <= seg_in;
      pos_ff <= pos_in;
   end

   `MU8QL_ASSERT_IMPLIES(a_pos_in_seg, b_valid_ff, pos_ff < cur_len, "position past segment end")
   `MU8QL_ASSERT_IMPLIES(a_err_last, b_valid_ff && cur.kind == SEG_ERR, is_last, "error not final")

endmodule

// ----- rtl/modified_utf8_to_quoted_literal_top.sv -----
// ---------------------------------------------------------------------------
// modified_utf8_to_quoted_literal_top
// Class-file modified UTF-8 byte stream to a double-quoted string literal.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one transfer per encoded byte (tuser 0) or per end of string
//   (tuser 1). rsp channel: one transfer per literal text byte; tuser carries
//   the error code, tlast marks the final byte caused by one request.
//   csr_wr_en/csr_wr_data set the hex case of u escapes; write it only while
//   the block is idle.
// Result path: a request is registered in the decode register and then in the
//   output register before its first result byte goes valid on rsp.
// Throughput: one request per cycle while each request gives at most one
//   byte and rsp_tready is held high; one request gives at most 12 bytes.
//   Requests that give no bytes never reach rsp.
// The decode register and the output register form a two-deep queue, so a
//   request is taken while the previous result still waits on rsp_tready.
// Reset clears the pending buffer state, the string flags, both stages and
//   the hex case register; a stalled receiver holds the current byte stable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module modified_utf8_to_quoted_literal_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,   // hex_upper
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // in_byte
   input  logic       req_tuser,     // opcode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // out_byte
   output logic [1:0] rsp_tuser,     // error_code
   output logic       rsp_tlast      // last_of_run
);
   import mu8ql_pkg::*;

   logic    hex_upper_ff;
   logic    rec_valid;
   logic    rec_take;
   rec_type rec_data;

   // hex case register
   always_ff @(posedge clock) begin
      if (reset) begin
         hex_upper_ff <= 1'b0;
      end else if (csr_wr_en) begin
         hex_upper_ff <= csr_wr_data;
      end
   end

   mu8ql_dec u_dec (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rec_valid  (rec_valid),
      .rec_data   (rec_data),
      .rec_take   (rec_take)
   );

   mu8ql_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .hex_upper  (hex_upper_ff),
      .rec_valid  (rec_valid),
      .rec_data   (rec_data),
      .rec_take   (rec_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
